FILE: rtl/gwlt_pkg.sv
// ---------------------------------------------------------------------------
// gwlt_pkg
// Shared types and constants of the gear window lock tracker: field widths,
// register map, gear and lock codes, and the indicator voltage table.
// ---------------------------------------------------------------------------
package gwlt_pkg;

  // Result field widths.
  localparam int GEAR_W   = 3;
  localparam int DAC_W    = 12;
  localparam int LOCK_W   = 2;
  localparam int FAIL_W   = 8;

  // Register widths.
  localparam int RELOAD_W = 8;
  localparam int GROUP_W  = 60;
  localparam int SIXTH_W  = 20;
  localparam int WIN_SLOTS = 3;
  localparam int NUM_WINDOWS = 7;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_LSB = 3;
  localparam int CFG_IDX_W = 3;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LOW        = 3'd0,
    REG_WIN_MID        = 3'd1,
    REG_WIN_SIXTH      = 3'd2,
    REG_LOCK_RELOAD    = 3'd3,
    REG_UNLOCK_RELOAD  = 3'd4,
    REG_FAIL_RELOAD    = 3'd5,
    REG_UNKNOWN_RELOAD = 3'd6
  } cfg_reg_t;

  // Reload values after reset.
  localparam logic [RELOAD_W-1:0] LOCK_RELOAD_RST    = 8'd10;
  localparam logic [RELOAD_W-1:0] UNLOCK_RELOAD_RST  = 8'd10;
  localparam logic [RELOAD_W-1:0] FAIL_RELOAD_RST    = 8'd10;
  localparam logic [RELOAD_W-1:0] UNKNOWN_RELOAD_RST = 8'd100;

  // Gear codes.
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;
  localparam logic [GEAR_W-1:0] GEAR_UNKNOWN = 3'd7;

  // Lock status as reported on the result channel.
  localparam logic [LOCK_W-1:0] LOCK_CODE_LOCKED   = 2'd0;
  localparam logic [LOCK_W-1:0] LOCK_CODE_UNLOCKED = 2'd1;
  localparam logic [LOCK_W-1:0] LOCK_CODE_FAILED   = 2'd2;

  // Lock state machine.
  typedef enum logic [2:0] {
    ST_LOCKED   = 3'b001,
    ST_UNLOCKED = 3'b010,
    ST_FAILED   = 3'b100
  } lock_state_t;

  // Indicator voltage for neutral and unknown.
  localparam logic [DAC_W-1:0] DAC_LAMP_MV = 12'd500;

  // Indicator voltage in millivolts for each gear.
  function automatic logic [DAC_W-1:0] dac_for_gear(input logic [GEAR_W-1:0] gear);
    logic [DAC_W-1:0] mv;
    case (gear)
      3'd1:    mv = 12'd1000;
      3'd2:    mv = 12'd1500;
      3'd3:    mv = 12'd2000;
      3'd4:    mv = 12'd2500;
      3'd5:    mv = 12'd3000;
      3'd6:    mv = 12'd3500;
      default: mv = DAC_LAMP_MV;
    endcase
    return mv;
  endfunction

endpackage

FILE: rtl/gwlt_stream_if.sv
// ---------------------------------------------------------------------------
// gwlt_stream_if
// Valid/ready channels of the gear window lock tracker: the sample channel
// and the result channel. A transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface gwlt_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gwlt_out_if;
  logic                           valid;
  logic                           ready;
  logic [gwlt_pkg::GEAR_W-1:0]    gear;
  logic [gwlt_pkg::GEAR_W-1:0]    gear_code;
  logic [gwlt_pkg::DAC_W-1:0]     dac_millivolts;
  logic                           lamp_on;
  logic [gwlt_pkg::LOCK_W-1:0]    lock_state;
  logic [gwlt_pkg::FAIL_W-1:0]    failure_total;

  modport source (output valid, output gear, output gear_code, output dac_millivolts,
                  output lamp_on, output lock_state, output failure_total, input ready);
  modport sink   (input valid, input gear, input gear_code, input dac_millivolts,
                  input lamp_on, input lock_state, input failure_total, output ready);
endinterface

FILE: rtl/gear_window_lock_tracker_core.sv
// ---------------------------------------------------------------------------
// gear_window_lock_tracker_core
// Sorts each position-sensor sample into neutral, gears one to six or
// unknown, and follows how steady the readings are with a lock state machine.
//
//   Channel    Direction  Handshake      Content
//   in_stream  sink       valid/ready    sample
//   out_stream source     valid/ready    gear, gear_code, dac_millivolts,
//                                        lamp_on, lock_state, failure_total
//   APB        slave      psel/penable   seven configuration registers, 64 bit
//
// One sample per cycle is taken while the result channel is not stalled;
// a transferred sample waits in the sample register, then the window compares
// and the lock update feed the result register.
// Reset (synchronous, active low) loads the reload registers with their
// defaults, clears the windows and starts locked on neutral.
// A stalled result register holds the sample stage; the sample stage still
// takes a transfer while it is empty.
// ---------------------------------------------------------------------------
module gear_window_lock_tracker_core #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  gwlt_in_if.sink                             in_stream,
  gwlt_out_if.source                          out_stream,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gwlt_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [gwlt_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [gwlt_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import gwlt_pkg::*;

  // Registers are zero-extended far enough that every bound lies inside.
  localparam int EXT_W = 4 * WIN_SLOTS * SAMPLE_BITS + 2 * SAMPLE_BITS;

  // Configuration registers.
  logic [GROUP_W-1:0]  win_low_r;
  logic [GROUP_W-1:0]  win_mid_r;
  logic [SIXTH_W-1:0]  win_sixth_r;
  logic [RELOAD_W-1:0] lock_reload_r;
  logic [RELOAD_W-1:0] unlock_reload_r;
  logic [RELOAD_W-1:0] fail_reload_r;
  logic [RELOAD_W-1:0] unknown_reload_r;

  cfg_reg_t            cfg_idx;
  logic                cfg_wr;

  // Pipeline registers.
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r;
  logic [GEAR_W-1:0]      out_gear_r;
  logic [GEAR_W-1:0]      out_code_r;
  logic [DAC_W-1:0]       out_dac_r;
  logic                   out_lamp_r;
  logic [LOCK_W-1:0]      out_lock_r;
  logic [FAIL_W-1:0]      out_fail_r;
  logic                   s1_advance;

  // Lock tracking state.
  lock_state_t         status_r, status_nxt;
  logic [GEAR_W-1:0]   last_gear_r;
  logic [COUNT_BITS-1:0] lock_down_r, lock_down_nxt;
  logic [COUNT_BITS-1:0] unlock_down_r, unlock_down_nxt;
  logic [COUNT_BITS-1:0] fail_down_r, fail_down_nxt;
  logic [COUNT_BITS-1:0] unknown_down_r, unknown_down_nxt;
  logic [FAIL_W-1:0]   failures_r, failures_nxt;

  // Classification.
  logic [EXT_W-1:0]       low_ext, mid_ext, sixth_ext;
  logic [SAMPLE_BITS-1:0] win_lo [NUM_WINDOWS];
  logic [SAMPLE_BITS-1:0] win_hi [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] win_hit;
  logic [GEAR_W-1:0]      gear;
  logic                   known;
  logic [LOCK_W-1:0]      lock_code;

  // Configuration port: always ready, register index from the address.
  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_IDX_LSB +: CFG_IDX_W]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r        <= '0;
      win_mid_r        <= '0;
      win_sixth_r      <= '0;
      lock_reload_r    <= LOCK_RELOAD_RST;
      unlock_reload_r  <= UNLOCK_RELOAD_RST;
      fail_reload_r    <= FAIL_RELOAD_RST;
      unknown_reload_r <= UNKNOWN_RELOAD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIN_LOW:        win_low_r        <= pwdata[GROUP_W-1:0];
        REG_WIN_MID:        win_mid_r        <= pwdata[GROUP_W-1:0];
        REG_WIN_SIXTH:      win_sixth_r      <= pwdata[SIXTH_W-1:0];
        REG_LOCK_RELOAD:    lock_reload_r    <= pwdata[RELOAD_W-1:0];
        REG_UNLOCK_RELOAD:  unlock_reload_r  <= pwdata[RELOAD_W-1:0];
        REG_FAIL_RELOAD:    fail_reload_r    <= pwdata[RELOAD_W-1:0];
        REG_UNKNOWN_RELOAD: unknown_reload_r <= pwdata[RELOAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      REG_WIN_LOW:        prdata = CFG_DATA_W'(win_low_r);
      REG_WIN_MID:        prdata = CFG_DATA_W'(win_mid_r);
      REG_WIN_SIXTH:      prdata = CFG_DATA_W'(win_sixth_r);
      REG_LOCK_RELOAD:    prdata = CFG_DATA_W'(lock_reload_r);
      REG_UNLOCK_RELOAD:  prdata = CFG_DATA_W'(unlock_reload_r);
      REG_FAIL_RELOAD:    prdata = CFG_DATA_W'(fail_reload_r);
      REG_UNKNOWN_RELOAD: prdata = CFG_DATA_W'(unknown_reload_r);
      default:            prdata = '0;
    endcase
  end

  // Pipeline control: the sample stage moves on when the result slot is free.
  assign s1_advance      = !out_valid_r || out_stream.ready;
  assign in_stream.ready = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      s1_sample_r <= in_stream.sample;
    end
  end

  // Window bounds; a bound that falls past a register's top bit reads as zero.
  assign low_ext   = EXT_W'(win_low_r);
  assign mid_ext   = EXT_W'(win_mid_r);
  assign sixth_ext = EXT_W'(win_sixth_r);

  for (genvar w = 0; w < WIN_SLOTS; w++) begin : g_slot
    localparam int LO_POS = w * 2 * SAMPLE_BITS;
    localparam int HI_POS = LO_POS + SAMPLE_BITS;
    assign win_lo[w]             = low_ext[LO_POS +: SAMPLE_BITS];
    assign win_hi[w]             = low_ext[HI_POS +: SAMPLE_BITS];
    assign win_lo[w + WIN_SLOTS] = mid_ext[LO_POS +: SAMPLE_BITS];
    assign win_hi[w + WIN_SLOTS] = mid_ext[HI_POS +: SAMPLE_BITS];
  end
  assign win_lo[NUM_WINDOWS-1] = sixth_ext[0 +: SAMPLE_BITS];
  assign win_hi[NUM_WINDOWS-1] = sixth_ext[SAMPLE_BITS +: SAMPLE_BITS];

  // Parallel window compares, then the first hit in priority order wins.
  always_comb begin
    for (int k = 0; k < NUM_WINDOWS; k++) begin
      win_hit[k] = (s1_sample_r >= win_lo[k]) && (s1_sample_r <= win_hi[k]);
    end
    gear = GEAR_UNKNOWN;
    for (int k = NUM_WINDOWS - 1; k >= 0; k--) begin
      if (win_hit[k]) begin
        gear = GEAR_W'(k);
      end
    end
  end

  // Lock state machine and its countdowns.
  always_comb begin
    status_nxt       = status_r;
    lock_down_nxt    = lock_down_r;
    unlock_down_nxt  = unlock_down_r;
    fail_down_nxt    = fail_down_r;
    unknown_down_nxt = unknown_down_r;
    failures_nxt     = failures_r;
    case (status_r)
      ST_LOCKED: begin
        if (last_gear_r == gear) begin
          if (gear == GEAR_UNKNOWN) begin
            if (unknown_down_r == '0) begin
              status_nxt = ST_UNLOCKED;
            end
            unknown_down_nxt = unknown_down_r - 1'b1;
          end else begin
            unknown_down_nxt = COUNT_BITS'(unknown_reload_r);
          end
          fail_down_nxt   = COUNT_BITS'(fail_reload_r);
          lock_down_nxt   = COUNT_BITS'(lock_reload_r);
          unlock_down_nxt = COUNT_BITS'(unlock_reload_r);
        end else begin
          lock_down_nxt = lock_down_r - 1'b1;
          if (lock_down_nxt == '0) begin
            status_nxt = ST_UNLOCKED;
          end
        end
      end
      ST_UNLOCKED: begin
        if (last_gear_r == gear) begin
          unlock_down_nxt = unlock_down_r - 1'b1;
          fail_down_nxt   = COUNT_BITS'(fail_reload_r);
          if (unlock_down_nxt == '0) begin
            status_nxt       = ST_LOCKED;
            unknown_down_nxt = COUNT_BITS'(unknown_reload_r);
          end
        end else begin
          fail_down_nxt = fail_down_r - 1'b1;
          if (fail_down_nxt == '0) begin
            status_nxt = ST_FAILED;
          end
        end
      end
      default: begin
        failures_nxt    = failures_r + 1'b1;
        status_nxt      = ST_UNLOCKED;
        unlock_down_nxt = COUNT_BITS'(unlock_reload_r);
        fail_down_nxt   = COUNT_BITS'(fail_reload_r);
      end
    endcase
  end

  // Reported lock status after this sample.
  always_comb begin
    case (status_nxt)
      ST_LOCKED:   lock_code = LOCK_CODE_LOCKED;
      ST_UNLOCKED: lock_code = LOCK_CODE_UNLOCKED;
      default:     lock_code = LOCK_CODE_FAILED;
    endcase
  end

  assign known = (gear != GEAR_NEUTRAL) && (gear != GEAR_UNKNOWN);

  // State update at the sample stage's transfer into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r       <= ST_LOCKED;
      last_gear_r    <= GEAR_NEUTRAL;
      lock_down_r    <= COUNT_BITS'(LOCK_RELOAD_RST);
      unlock_down_r  <= COUNT_BITS'(UNLOCK_RELOAD_RST);
      fail_down_r    <= COUNT_BITS'(FAIL_RELOAD_RST);
      unknown_down_r <= COUNT_BITS'(UNKNOWN_RELOAD_RST);
      failures_r     <= '0;
    end else if (s1_valid_r && s1_advance) begin
      status_r       <= status_nxt;
      last_gear_r    <= gear;
      lock_down_r    <= lock_down_nxt;
      unlock_down_r  <= unlock_down_nxt;
      fail_down_r    <= fail_down_nxt;
      unknown_down_r <= unknown_down_nxt;
      failures_r     <= failures_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_advance) begin
      out_gear_r <= gear;
      out_code_r <= known ? gear : GEAR_NEUTRAL;
      out_dac_r  <= dac_for_gear(gear);
      out_lamp_r <= !known;
      out_lock_r <= lock_code;
      out_fail_r <= failures_nxt;
    end
  end

  assign out_stream.valid          = out_valid_r;
  assign out_stream.gear           = out_gear_r;
  assign out_stream.gear_code      = out_code_r;
  assign out_stream.dac_millivolts = out_dac_r;
  assign out_stream.lamp_on        = out_lamp_r;
  assign out_stream.lock_state     = out_lock_r;
  assign out_stream.failure_total  = out_fail_r;

endmodule

FILE: rtl/gwlt_checker.sv
// ---------------------------------------------------------------------------
// gwlt_checker
// Port-level checks of the gear window lock tracker's result channel,
// attached to the core module by a bind statement.
// ---------------------------------------------------------------------------
module gwlt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gwlt_pkg::GEAR_W-1:0]   out_gear,
  input logic [gwlt_pkg::GEAR_W-1:0]   out_gear_code,
  input logic [gwlt_pkg::DAC_W-1:0]    out_dac_millivolts,
  input logic                          out_lamp_on,
  input logic [gwlt_pkg::LOCK_W-1:0]   out_lock_state
);
  import gwlt_pkg::*;

  // No result is offered in the cycle after reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A result that is not taken stays offered.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // The lamp is lit exactly when the code shows neutral.
  a_lamp_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lamp_on == (out_gear_code == GEAR_NEUTRAL)))
    else $error("lamp disagrees with gear code");

  // Unknown reports code zero and the neutral indicator voltage.
  a_unknown_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gear == GEAR_UNKNOWN) |->
      (out_gear_code == GEAR_NEUTRAL) && (out_dac_millivolts == DAC_LAMP_MV))
    else $error("unknown gear reported with wrong code or voltage");

  // The lock status never takes the unused code.
  a_lock_code_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lock_state == LOCK_CODE_LOCKED) ||
      (out_lock_state == LOCK_CODE_UNLOCKED) || (out_lock_state == LOCK_CODE_FAILED))
    else $error("lock status carries an unused code");

endmodule

bind gear_window_lock_tracker_core gwlt_checker u_gwlt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_stream.valid),
  .out_ready         (out_stream.ready),
  .out_gear          (out_stream.gear),
  .out_gear_code     (out_stream.gear_code),
  .out_dac_millivolts(out_stream.dac_millivolts),
  .out_lamp_on       (out_stream.lamp_on),
  .out_lock_state    (out_stream.lock_state)
);

FILE: bench/gear_window_lock_tracker_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gear_window_lock_tracker_core_tb
// Self-checking bench for the gear window lock tracker. A behavioral copy of
// the window sort and the lock state machine predicts every result. Directed
// window edges and register corner cases come first. Runs of samples aimed at
// one gear follow, under several idling mixes, with failure churn, zero
// reloads and a long receiver hold-off.
// ---------------------------------------------------------------------------
module gear_window_lock_tracker_core_tb;
  import gwlt_pkg::*;

  localparam int SAMPLE_BITS = 10;
  localparam int COUNT_BITS  = 8;
  localparam int CLK_HALF_NS = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DAC_STEP_MV = 500;
  localparam int RUN_CAP     = 64;
  localparam logic [CFG_IDX_W-1:0]   REG_SPARE  = 3'd7;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef logic [SAMPLE_BITS-1:0] bound_t;

  typedef struct packed {
    logic [GEAR_W-1:0] gear;
    logic [GEAR_W-1:0] gear_code;
    logic [DAC_W-1:0]  dac_millivolts;
    logic              lamp_on;
    logic [LOCK_W-1:0] lock_state;
    logic [FAIL_W-1:0] failure_total;
  } gear_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  gwlt_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  gwlt_out_if result_ch ();

  gear_window_lock_tracker_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (sample_ch),
    .out_stream(result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Shadow copy of the registers.
  logic [GROUP_W-1:0]  win_low_reg;
  logic [GROUP_W-1:0]  win_mid_reg;
  logic [SIXTH_W-1:0]  win_sixth_reg;
  logic [RELOAD_W-1:0] rl_lock;
  logic [RELOAD_W-1:0] rl_unlock;
  logic [RELOAD_W-1:0] rl_fail;
  logic [RELOAD_W-1:0] rl_unknown;

  // Shadow copy of the lock tracking state.
  logic [LOCK_W-1:0]     track_status;
  logic [GEAR_W-1:0]     track_last_gear;
  logic [COUNT_BITS-1:0] lock_left;
  logic [COUNT_BITS-1:0] unlock_left;
  logic [COUNT_BITS-1:0] fail_left;
  logic [COUNT_BITS-1:0] unknown_left;
  logic [FAIL_W-1:0]     track_failures;

  gear_result_t expected_results[$];

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;
  int mismatch_count;
  int samples_sent;
  int results_checked;
  int cycle_count;

  // Free-running clock.
  always begin
    clk = 1'b0;
    #CLK_HALF_NS;
    clk = 1'b1;
    #CLK_HALF_NS;
  end

  // Bounds of window k as {upper, lower}.
  function automatic logic [2*SAMPLE_BITS-1:0] window_of(input int k);
    if (k < WIN_SLOTS) begin
      return win_low_reg[k*2*SAMPLE_BITS +: 2*SAMPLE_BITS];
    end else if (k < 2*WIN_SLOTS) begin
      return win_mid_reg[(k-WIN_SLOTS)*2*SAMPLE_BITS +: 2*SAMPLE_BITS];
    end
    return win_sixth_reg[2*SAMPLE_BITS-1:0];
  endfunction

  // The lowest-numbered window that holds the sample wins.
  function automatic logic [GEAR_W-1:0] classify_sample(input bound_t s);
    logic [2*SAMPLE_BITS-1:0] w;
    logic [GEAR_W-1:0]        g;
    g = GEAR_UNKNOWN;
    for (int k = NUM_WINDOWS - 1; k >= 0; k--) begin
      w = window_of(k);
      if (s >= w[SAMPLE_BITS-1:0] && s <= w[2*SAMPLE_BITS-1:SAMPLE_BITS]) begin
        g = GEAR_W'(k);
      end
    end
    return g;
  endfunction

  // Advance the lock state machine by one sample and queue the result.
  task automatic predict_result(input bound_t s);
    logic [GEAR_W-1:0] g;
    logic              known;
    gear_result_t      r;
    g = classify_sample(s);
    case (track_status)
      LOCK_CODE_LOCKED: begin
        if (track_last_gear == g) begin
          if (g == GEAR_UNKNOWN) begin
            // The old count is tested before the wrapping decrement.
            if (unknown_left == '0) track_status = LOCK_CODE_UNLOCKED;
            unknown_left = unknown_left - 1'b1;
          end else begin
            unknown_left = COUNT_BITS'(rl_unknown);
          end
          fail_left   = COUNT_BITS'(rl_fail);
          lock_left   = COUNT_BITS'(rl_lock);
          unlock_left = COUNT_BITS'(rl_unlock);
        end else begin
          lock_left = lock_left - 1'b1;
          if (lock_left == '0) track_status = LOCK_CODE_UNLOCKED;
        end
      end
      LOCK_CODE_UNLOCKED: begin
        if (track_last_gear == g) begin
          unlock_left = unlock_left - 1'b1;
          fail_left   = COUNT_BITS'(rl_fail);
          if (unlock_left == '0) begin
            track_status = LOCK_CODE_LOCKED;
            unknown_left = COUNT_BITS'(rl_unknown);
          end
        end else begin
          fail_left = fail_left - 1'b1;
          if (fail_left == '0) track_status = LOCK_CODE_FAILED;
        end
      end
      default: begin
        track_failures = track_failures + 1'b1;
        track_status   = LOCK_CODE_UNLOCKED;
        unlock_left    = COUNT_BITS'(rl_unlock);
        fail_left      = COUNT_BITS'(rl_fail);
      end
    endcase
    track_last_gear = g;

    known = (g != GEAR_NEUTRAL) && (g != GEAR_UNKNOWN);
    r.gear           = g;
    r.gear_code      = known ? g : GEAR_NEUTRAL;
    r.dac_millivolts = known ? DAC_W'(DAC_STEP_MV + DAC_STEP_MV * g) : DAC_LAMP_MV;
    r.lamp_on        = !known;
    r.lock_state     = track_status;
    r.failure_total  = track_failures;
    expected_results.push_back(r);
  endtask

  // Mirror a register write; bits beyond each field are dropped.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_WIN_LOW:        win_low_reg   = value[GROUP_W-1:0];
      REG_WIN_MID:        win_mid_reg   = value[GROUP_W-1:0];
      REG_WIN_SIXTH:      win_sixth_reg = value[SIXTH_W-1:0];
      REG_LOCK_RELOAD:    rl_lock       = value[RELOAD_W-1:0];
      REG_UNLOCK_RELOAD:  rl_unlock     = value[RELOAD_W-1:0];
      REG_FAIL_RELOAD:    rl_fail       = value[RELOAD_W-1:0];
      REG_UNKNOWN_RELOAD: rl_unknown    = value[RELOAD_W-1:0];
      default: ;
    endcase
  endfunction

  // One register write: setup cycle, then access until pready.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write all four reloads, with junk in the unused upper bits.
  task automatic write_reloads(input logic [RELOAD_W-1:0] lock_v,
                               input logic [RELOAD_W-1:0] unlock_v,
                               input logic [RELOAD_W-1:0] fail_v,
                               input logic [RELOAD_W-1:0] unknown_v);
    logic [CFG_DATA_W-1:0] v;
    v = {$urandom, $urandom};
    v[RELOAD_W-1:0] = lock_v;
    write_register(REG_LOCK_RELOAD, v);
    v = {$urandom, $urandom};
    v[RELOAD_W-1:0] = unlock_v;
    write_register(REG_UNLOCK_RELOAD, v);
    v = {$urandom, $urandom};
    v[RELOAD_W-1:0] = fail_v;
    write_register(REG_FAIL_RELOAD, v);
    v = {$urandom, $urandom};
    v[RELOAD_W-1:0] = unknown_v;
    write_register(REG_UNKNOWN_RELOAD, v);
  endtask

  // Pack seven windows into the three window registers.
  task automatic write_windows(input bound_t lo [NUM_WINDOWS], input bound_t hi [NUM_WINDOWS]);
    logic [CFG_DATA_W-1:0] low_v;
    logic [CFG_DATA_W-1:0] mid_v;
    logic [CFG_DATA_W-1:0] six_v;
    low_v = {$urandom, $urandom};
    mid_v = {$urandom, $urandom};
    six_v = {$urandom, $urandom};
    for (int k = 0; k < WIN_SLOTS; k++) begin
      low_v[k*2*SAMPLE_BITS +: 2*SAMPLE_BITS] = {hi[k], lo[k]};
      mid_v[k*2*SAMPLE_BITS +: 2*SAMPLE_BITS] = {hi[k+WIN_SLOTS], lo[k+WIN_SLOTS]};
    end
    six_v[2*SAMPLE_BITS-1:0] = {hi[NUM_WINDOWS-1], lo[NUM_WINDOWS-1]};
    write_register(REG_WIN_LOW, low_v);
    write_register(REG_WIN_MID, mid_v);
    write_register(REG_WIN_SIXTH, six_v);
  endtask

  // Windows at k*100 .. k*100+89, the sixth up to full scale; gaps are unknown.
  task automatic write_fixed_windows();
    bound_t lo [NUM_WINDOWS];
    bound_t hi [NUM_WINDOWS];
    for (int k = 0; k < NUM_WINDOWS; k++) begin
      lo[k] = bound_t'(k * 100);
      hi[k] = bound_t'(k * 100 + 89);
    end
    hi[NUM_WINDOWS-1] = SAMPLE_MAX;
    write_windows(lo, hi);
  endtask

  // Mostly ordered windows with gaps; now and then an empty or a stray one.
  task automatic randomize_windows();
    bound_t lo [NUM_WINDOWS];
    bound_t hi [NUM_WINDOWS];
    int     base;
    int     pick;
    base = 0;
    for (int k = 0; k < NUM_WINDOWS; k++) begin
      lo[k] = bound_t'(base + $urandom_range(0, 30));
      hi[k] = bound_t'(lo[k] + $urandom_range(10, 110));
      base  = hi[k] + 1;
      pick  = $urandom_range(0, 15);
      if (pick == 0) begin
        {lo[k], hi[k]} = {hi[k], lo[k]};
      end else if (pick == 1) begin
        lo[k] = bound_t'($urandom_range(0, SAMPLE_MAX));
        hi[k] = bound_t'($urandom_range(0, SAMPLE_MAX));
      end
    end
    if ($urandom_range(0, 1)) hi[NUM_WINDOWS-1] = SAMPLE_MAX;
    write_windows(lo, hi);
  endtask

  // Offer one sample, with random idle cycles ahead of it, until it transfers.
  task automatic send_sample(input bound_t s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predict_result(s);
    samples_sent++;
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic wait_for_drain();
    sample_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // A sample that the current windows sort into the given gear, if one is found.
  function automatic bound_t sample_for_gear(input logic [GEAR_W-1:0] target);
    logic [2*SAMPLE_BITS-1:0] w;
    bound_t                   s;
    for (int tries = 0; tries < 64; tries++) begin
      s = bound_t'($urandom_range(0, SAMPLE_MAX));
      if (target != GEAR_UNKNOWN && tries < 32) begin
        w = window_of(int'(target));
        if (w[SAMPLE_BITS-1:0] <= w[2*SAMPLE_BITS-1:SAMPLE_BITS]) begin
          s = bound_t'($urandom_range(w[SAMPLE_BITS-1:0], w[2*SAMPLE_BITS-1:SAMPLE_BITS]));
        end
      end
      if (classify_sample(s) == target) return s;
    end
    return s;
  endfunction

  // Runs of samples aimed at one gear, some long enough to cross the countdowns,
  // mixed with some full-range noise.
  task automatic send_gear_runs(input int count, input int noise_pct);
    logic [GEAR_W-1:0] target;
    int                run_len;
    int                longest;
    int                sent;
    sent = 0;
    while (sent < count) begin
      target  = GEAR_W'($urandom_range(0, 7));
      longest = (target == GEAR_UNKNOWN) ? rl_unknown + 3 : rl_unlock + 3;
      if (longest > RUN_CAP) longest = RUN_CAP;
      run_len = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, longest);
      for (int i = 0; i < run_len && sent < count; i++) begin
        if ($urandom_range(0, 99) < noise_pct) begin
          send_sample(bound_t'($urandom_range(0, SAMPLE_MAX)));
        end else begin
          send_sample(sample_for_gear(target));
        end
        sent++;
      end
    end
  endtask

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    gear_result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("Result transfer with no expectation waiting: gear %0d", result_ch.gear);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("gear", 32'(want.gear), 32'(result_ch.gear));
        check_field("gear_code", 32'(want.gear_code), 32'(result_ch.gear_code));
        check_field("dac_millivolts", 32'(want.dac_millivolts),
                    32'(result_ch.dac_millivolts));
        check_field("lamp_on", 32'(want.lamp_on), 32'(result_ch.lamp_on));
        check_field("lock_state", 32'(want.lock_state), 32'(result_ch.lock_state));
        check_field("failure_total", 32'(want.failure_total),
                    32'(result_ch.failure_total));
        results_checked++;
      end
    end
  end

  // Result-side ready: random stalls, or a held-off stretch on request.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Zero windows after reset: sample zero sits in every window and neutral wins.
  task automatic test_reset_defaults();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(10'h2AA);
    send_sample(10'h155);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    wait_for_drain();
  endtask

  // Both bounds of every window, the gap after neutral and full scale.
  task automatic test_window_edges();
    int probes [18] = '{0, 89, 90, 100, 189, 200, 289, 300, 389,
                        400, 489, 500, 589, 600, 689, 695, 700, 1023};
    write_fixed_windows();
    // A write past the last register must change nothing.
    write_register(REG_SPARE, {$urandom, $urandom});
    for (int i = 0; i < 18; i++) begin
      send_sample(bound_t'(probes[i]));
    end
    wait_for_drain();
  endtask

  // Empty neutral window, overlapping windows for gears one and two.
  task automatic test_priority_and_empty();
    bound_t lo [NUM_WINDOWS];
    bound_t hi [NUM_WINDOWS];
    for (int k = 0; k < NUM_WINDOWS; k++) begin
      lo[k] = SAMPLE_MAX;
      hi[k] = '0;
    end
    lo[0] = 60;
    hi[0] = 20;
    lo[1] = 0;
    hi[1] = 150;
    lo[2] = 0;
    hi[2] = SAMPLE_MAX;
    write_windows(lo, hi);
    send_sample(5);
    send_sample(150);
    send_sample(151);
    send_sample(SAMPLE_MAX);
    wait_for_drain();
  endtask

  task automatic test_runs_no_idle();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_reloads(RELOAD_W'($urandom_range(1, 12)), RELOAD_W'($urandom_range(1, 12)),
                  RELOAD_W'($urandom_range(1, 12)), RELOAD_W'($urandom_range(1, 12)));
    randomize_windows();
    send_gear_runs(250, 15);
    wait_for_drain();
  endtask

  // Reloads of one: every change moves the state machine.
  task automatic test_runs_sender_idle();
    sender_idle_pct = 75;
    recv_stall_pct  = 0;
    write_reloads(1, 1, 1, 1);
    randomize_windows();
    send_gear_runs(250, 15);
    wait_for_drain();
  endtask

  // Largest lock and fail reloads, short unlock and unknown reloads.
  task automatic test_runs_receiver_stall();
    sender_idle_pct = 0;
    recv_stall_pct  = 75;
    write_reloads(8'hFF, 3, 8'hFF, 2);
    randomize_windows();
    send_gear_runs(250, 15);
    wait_for_drain();
  endtask

  task automatic test_runs_both_idle();
    sender_idle_pct = 25;
    recv_stall_pct  = 25;
    write_reloads(RELOAD_W'($urandom_range(1, 16)), RELOAD_W'($urandom_range(1, 16)),
                  RELOAD_W'($urandom_range(1, 16)), RELOAD_W'($urandom_range(1, 16)));
    randomize_windows();
    send_gear_runs(250, 15);
    wait_for_drain();
  endtask

  // Fast lock failures on random samples, to drive the failure count up.
  task automatic test_failure_churn();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_fixed_windows();
    write_reloads(1, 2, 1, 1);
    for (int i = 0; i < 450; i++) begin
      send_sample(bound_t'($urandom_range(0, SAMPLE_MAX)));
    end
    wait_for_drain();
  endtask

  // Zero lock reload takes a full wrap of the countdown to unlock; a zero
  // unknown reload unlocks on the first repeated unknown.
  task automatic test_zero_reloads();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_reloads(0, 1, 1, 0);
    repeat (7) send_sample(sample_for_gear(3));
    for (int i = 0; i < 270; i++) begin
      send_sample(sample_for_gear(GEAR_W'((i % 2) ? 4 : 2)));
    end
    repeat (6) send_sample(sample_for_gear(3));
    repeat (12) send_sample(sample_for_gear(GEAR_UNKNOWN));
    wait_for_drain();
  endtask

  // Long receiver hold-off while samples keep coming, then a full pause.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_reloads(4, 3, 5, 6);
    randomize_windows();
    hold_request = 200;
    send_gear_runs(40, 30);
    wait_for_drain();
    send_gear_runs(20, 30);
    wait_for_drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    result_ch.ready  = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sender_idle_pct  = 0;
    recv_stall_pct   = 0;
    hold_request     = 0;
    hold_left        = 0;
    mismatch_count   = 0;
    samples_sent     = 0;
    results_checked  = 0;
    cycle_count      = 0;

    // State after reset.
    win_low_reg     = '0;
    win_mid_reg     = '0;
    win_sixth_reg   = '0;
    rl_lock         = LOCK_RELOAD_RST;
    rl_unlock       = UNLOCK_RELOAD_RST;
    rl_fail         = FAIL_RELOAD_RST;
    rl_unknown      = UNKNOWN_RELOAD_RST;
    track_status    = LOCK_CODE_LOCKED;
    track_last_gear = GEAR_NEUTRAL;
    lock_left       = COUNT_BITS'(rl_lock);
    unlock_left     = COUNT_BITS'(rl_unlock);
    fail_left       = COUNT_BITS'(rl_fail);
    unknown_left    = COUNT_BITS'(rl_unknown);
    track_failures  = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_window_edges();
    test_priority_and_empty();
    test_runs_no_idle();
    test_runs_sender_idle();
    test_runs_receiver_stall();
    test_runs_both_idle();
    test_failure_churn();
    test_zero_reloads();
    test_backpressure();

    wait_for_drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d samples: window edges, priority, empty windows,",
             results_checked, samples_sent);
    $display("gear runs under four idling mixes, failure churn, zero reloads, long hold-off.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/gwlt_pkg.sv
rtl/gwlt_stream_if.sv
rtl/gear_window_lock_tracker_core.sv
rtl/gwlt_checker.sv
bench/gear_window_lock_tracker_core_tb.sv
